/* rtl/ura_pkg.sv */
// ura_pkg: shared types and constants for the ultrasonic range alarm core.
// Holds the phase enum, the word structs and the fixed-point scale factors.
// No dependencies.
package ura_pkg;

    localparam int COUNT_BITS_DEF = 20;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 20;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DIST = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALARM_Q4 = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT  = 2'd2;

    localparam int MAX_DIST_BITS = 10;
    localparam int DIST_CM_BITS  = 14;
    localparam int DIST_IN_BITS  = 13;
    localparam int WAIT_BITS     = 20;
    localparam int PT_BITS       = 4;

    localparam logic [WAIT_BITS-1:0]     WAIT_MAX        = '1;
    localparam logic [WAIT_BITS-1:0]     TIMEOUT_RST     = 20'd1000000;
    localparam logic [MAX_DIST_BITS-1:0] MAX_DIST_RST    = 10'd400;
    localparam logic [PT_BITS-1:0]       TRIG_LOW_TICKS  = 4'd2;
    localparam logic [PT_BITS-1:0]       TRIG_HIGH_TICKS = 4'd10;

    // echo ticks * 343 = 20000 * centimetres
    localparam int               PROD_EXTRA = 9;
    localparam logic [8:0]       ECHO_SCALE = 9'd343;
    localparam int               LIM_BITS   = 25;
    localparam logic [14:0]      LIM_SCALE  = 15'd20000;

    // rounded division by 1250 (cm q4) and 3175 (inch q4) via reciprocal
    localparam int               X_BITS     = 25;
    localparam int               RCP_BITS   = 26;
    localparam int               PROD_BITS  = X_BITS + RCP_BITS;
    localparam logic [X_BITS-1:0]   CM_BIAS = 25'd625;
    localparam logic [X_BITS-1:0]   IN_BIAS = 25'd1587;
    localparam logic [RCP_BITS-1:0] CM_RCP  = 26'd54975582;
    localparam logic [RCP_BITS-1:0] IN_RCP  = 26'd43287860;
    localparam int               CM_SHIFT   = 36;
    localparam int               IN_SHIFT   = 37;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TLOW  = 3'd1,
        PH_THIGH = 3'd2,
        PH_WLOW  = 3'd3,
        PH_WRISE = 3'd4,
        PH_COUNT = 3'd5
    } t_phase;

    typedef struct packed {
        logic trig;
        logic done;
    } t_flags;

    typedef struct packed {
        logic                    trig;
        logic                    done;
        logic                    valid;
        logic [DIST_CM_BITS-1:0] cm;
        logic [DIST_IN_BITS-1:0] inch;
    } t_reading;

endpackage

/* rtl/ura_seq.sv */
// ura_seq: trigger / echo sequencer stage, one tick word per advance.
// Produces trigger level, done flag and echo count into a stage register.
// Depends on ura_pkg.
module ura_seq #(
    parameter int COUNT_BITS = ura_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    input  logic                               i_start,
    input  logic                               i_echo,
    input  logic [ura_pkg::WAIT_BITS-1:0]      i_timeout,
    output logic                               o_ready,
    output logic                               o_vld,
    output ura_pkg::t_flags                    o_flags,
    output logic [COUNT_BITS-1:0]              o_count,
    input  logic                               i_ready
);
    import ura_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    t_phase                r_phase, n_phase;
    logic [PT_BITS-1:0]    r_pt, n_pt;
    logic [WAIT_BITS-1:0]  r_wait, n_wait;
    logic [COUNT_BITS-1:0] r_echo_cnt, n_echo_cnt;
    logic                  r_vld;
    t_flags                r_flags, n_flags;
    logic [COUNT_BITS-1:0] r_count, n_count;

    logic                  adv;
    logic [PT_BITS-1:0]    pt_inc;
    logic [WAIT_BITS-1:0]  wait_inc;
    logic                  in_wait;
    logic                  ev_fall;
    logic                  ev_tmo;

    assign o_ready  = !r_vld || i_ready;
    assign adv      = i_vld && o_ready;
    assign pt_inc   = r_pt + PT_BITS'(1);
    assign wait_inc = (r_wait == WAIT_MAX) ? r_wait : r_wait + WAIT_BITS'(1);
    assign in_wait  = (r_phase == PH_WLOW) || (r_phase == PH_WRISE) || (r_phase == PH_COUNT);
    assign ev_fall  = (r_phase == PH_COUNT) && !i_echo;
    assign ev_tmo   = in_wait && (wait_inc >= i_timeout);

    always_comb begin
        n_phase    = r_phase;
        n_pt       = r_pt;
        n_wait     = r_wait;
        n_echo_cnt = r_echo_cnt;
        case (r_phase)
            PH_TLOW: begin
                n_pt = pt_inc;
                if (pt_inc >= TRIG_LOW_TICKS) begin
                    n_phase = PH_THIGH;
                    n_pt    = '0;
                end
            end
            PH_THIGH: begin
                n_pt = pt_inc;
                if (pt_inc >= TRIG_HIGH_TICKS) begin
                    n_phase    = PH_WLOW;
                    n_pt       = '0;
                    n_wait     = '0;
                    n_echo_cnt = '0;
                end
            end
            PH_WLOW, PH_WRISE, PH_COUNT: begin
                n_wait = wait_inc;
                if (r_phase == PH_WLOW) begin
                    if (!i_echo) n_phase = PH_WRISE;
                end else if (r_phase == PH_WRISE) begin
                    if (i_echo) begin
                        n_phase    = PH_COUNT;
                        n_echo_cnt = COUNT_BITS'(1);
                    end
                end else if (i_echo && r_echo_cnt != CNT_MAX) begin
                    n_echo_cnt = r_echo_cnt + COUNT_BITS'(1);
                end
                if (ev_fall || ev_tmo) begin
                    n_phase = PH_IDLE;
                    n_pt    = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_start) begin
                    n_phase = PH_TLOW;
                    n_pt    = PT_BITS'(1);
                end
            end
        endcase
    end

    always_comb begin
        n_flags.trig = (r_phase == PH_THIGH);
        n_flags.done = ev_fall || ev_tmo;
        n_count      = ev_fall ? r_echo_cnt : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pt       <= '0;
            r_wait     <= '0;
            r_echo_cnt <= '0;
            r_vld      <= 1'b0;
        end else begin
            if (adv) begin
                r_phase    <= n_phase;
                r_pt       <= n_pt;
                r_wait     <= n_wait;
                r_echo_cnt <= n_echo_cnt;
            end
            if (o_ready) r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_flags <= n_flags;
            r_count <= n_count;
        end
    end

    assign o_vld   = r_vld;
    assign o_flags = r_flags;
    assign o_count = r_count;

`ifndef SYNTHESIS
    a_trig_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_flags.trig |-> !r_flags.done)
        else $error("trigger word flagged done");
    a_count_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && (r_count != '0) |-> r_flags.done)
        else $error("nonzero count without done");
    a_start_tlow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (r_phase == PH_IDLE) && i_start |=> (r_phase == PH_TLOW))
        else $error("start did not enter trigger low");
`endif

endmodule

/* rtl/ura_conv.sv */
// ura_conv: two-stage fixed-point conversion of the echo count.
// Stage 1 scales count and range limit, stage 2 checks range and divides.
// Depends on ura_pkg.
module ura_conv #(
    parameter int COUNT_BITS = ura_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    input  ura_pkg::t_flags                    i_flags,
    input  logic [COUNT_BITS-1:0]              i_count,
    input  logic [ura_pkg::MAX_DIST_BITS-1:0]  i_max_dist,
    output logic                               o_ready,
    output logic                               o_vld,
    output ura_pkg::t_reading                  o_rd,
    input  logic                               i_ready
);
    import ura_pkg::*;

    localparam int PW = COUNT_BITS + PROD_EXTRA;

    logic                 r1_vld;
    t_flags               r1_flags;
    logic [PW-1:0]        r1_p, n1_p;
    logic [LIM_BITS-1:0]  r_lim;
    logic                 r2_vld;
    t_reading             r2_rd, n2_rd;

    logic                 rdy1, rdy2;
    logic                 in_range;
    logic [X_BITS-1:0]    x_cm, x_in;
    logic [PROD_BITS-1:0] prod_cm, prod_in;

    assign rdy2    = !r2_vld || i_ready;
    assign rdy1    = !r1_vld || rdy2;
    assign o_ready = rdy1;

    assign n1_p = PW'(i_count) * PW'(ECHO_SCALE);

    assign in_range = r1_flags.done && (r1_p != '0) && (r1_p <= PW'(r_lim));
    assign x_cm     = r1_p[X_BITS-1:0] + CM_BIAS;
    assign x_in     = r1_p[X_BITS-1:0] + IN_BIAS;
    assign prod_cm  = PROD_BITS'(x_cm) * PROD_BITS'(CM_RCP);
    assign prod_in  = PROD_BITS'(x_in) * PROD_BITS'(IN_RCP);

    always_comb begin
        n2_rd.trig  = r1_flags.trig;
        n2_rd.done  = r1_flags.done;
        n2_rd.valid = in_range;
        n2_rd.cm    = in_range ? prod_cm[CM_SHIFT +: DIST_CM_BITS] : '0;
        n2_rd.inch  = in_range ? prod_in[IN_SHIFT +: DIST_IN_BITS] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            if (rdy1) r1_vld <= i_vld;
            if (rdy2) r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim <= LIM_BITS'(i_max_dist) * LIM_BITS'(LIM_SCALE);
        if (rdy1 && i_vld) begin
            r1_flags <= i_flags;
            r1_p     <= n1_p;
        end
        if (rdy2 && r1_vld) r2_rd <= n2_rd;
    end

    assign o_vld = r2_vld;
    assign o_rd  = r2_rd;

`ifndef SYNTHESIS
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld && r2_rd.valid |-> r2_rd.done)
        else $error("valid reading without done");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld && !r2_rd.valid |-> (r2_rd.cm == '0) && (r2_rd.inch == '0))
        else $error("invalid reading carries distance");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld && !i_ready |=> r2_vld && $stable(r2_rd))
        else $error("stalled reading changed");
`endif

endmodule

/* rtl/ura_track.sv */
// ura_track: change detection, alarm flag and output register.
// Keeps the last (valid, distance) pair and the alarm state.
// Depends on ura_pkg.
module ura_track (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    input  ura_pkg::t_reading                  i_rd,
    input  logic [ura_pkg::DIST_CM_BITS-1:0]   i_alarm_q4,
    output logic                               o_ready,
    output logic                               o_vld,
    output ura_pkg::t_reading                  o_rd,
    output logic                               o_alarm,
    output logic                               o_changed,
    input  logic                               i_ready
);
    import ura_pkg::*;

    logic                    r_last_valid;
    logic [DIST_CM_BITS-1:0] r_last_cm;
    logic                    r_alarm, n_alarm;
    logic                    r_vld;
    t_reading                r_rd;
    logic                    r_alarm_o;
    logic                    r_chg;

    logic                    adv;
    logic                    chg;

    assign o_ready = !r_vld || i_ready;
    assign adv     = i_vld && o_ready;
    assign chg     = i_rd.done && ((i_rd.valid != r_last_valid) || (i_rd.cm != r_last_cm));
    assign n_alarm = chg ? (i_rd.valid && (i_rd.cm >= i_alarm_q4)) : r_alarm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_valid <= 1'b1;
            r_last_cm    <= '0;
            r_alarm      <= 1'b0;
            r_vld        <= 1'b0;
        end else begin
            if (adv && chg) begin
                r_last_valid <= i_rd.valid;
                r_last_cm    <= i_rd.cm;
            end
            if (adv) r_alarm <= n_alarm;
            if (o_ready) r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd      <= i_rd;
            r_alarm_o <= n_alarm;
            r_chg     <= chg;
        end
    end

    assign o_vld     = r_vld;
    assign o_rd      = r_rd;
    assign o_alarm   = r_alarm_o;
    assign o_changed = r_chg;

`ifndef SYNTHESIS
    a_chg_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_chg |-> r_rd.done)
        else $error("change flagged without done");
    a_alarm_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alarm |-> r_last_valid)
        else $error("alarm held on invalid reading");
    a_alarm_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !chg |=> r_alarm == $past(r_alarm))
        else $error("alarm moved without a change");
`endif

endmodule

/* rtl/ultrasonic_range_alarm_core.sv */
// ultrasonic_range_alarm_core: top level of the ultrasonic range alarm.
// Input register, config registers, sequencer, conversion and tracking stages.
// Depends on ura_pkg, ura_seq, ura_conv, ura_track.
//
//   channel   dir  width  fields (lsb first)
//   s stream  in   8      start_req, echo_level, pad
//   m stream  out  32     trigger_level, done_res, reading_valid,
//                         distance_cm_q4[13:0], distance_in_q4[12:0], alarm, changed
//   cfg       in   2+20   index, data (written on i_cfg_we)
//
// One word per cycle in and out while the output is not stalled; each result passes
// through every register stage in turn before it leaves.
// The five register stages are input, sequencer, scale, divide and output.
// Synchronous reset loads config defaults and idles the sequencer; no memory to clear.
// A stall holds each full stage; empty stages keep filling, so bubbles close up.
module ultrasonic_range_alarm_core #(
    parameter int COUNT_BITS = ura_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,  // start_req, echo_level
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // trigger_level, done_res, reading_valid, distance_cm_q4, distance_in_q4, alarm, changed
    output logic [31:0]                        o_m_tdata,
    input  logic                               i_cfg_we,
    input  logic [ura_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [ura_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import ura_pkg::*;

    logic [MAX_DIST_BITS-1:0] r_max_dist;
    logic [DIST_CM_BITS-1:0]  r_alarm_q4;
    logic [WAIT_BITS-1:0]     r_timeout;

    logic                     r_in_vld;
    logic                     r_start;
    logic                     r_echo;

    logic                     seq_ready, seq_vld;
    t_flags                   seq_flags;
    logic [COUNT_BITS-1:0]    seq_count;
    logic                     conv_ready, conv_vld;
    t_reading                 conv_rd;
    logic                     trk_ready;
    t_reading                 out_rd;
    logic                     out_alarm, out_chg;

    assign o_s_tready = !r_in_vld || seq_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= MAX_DIST_RST;
            r_alarm_q4 <= '0;
            r_timeout  <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_DIST: r_max_dist <= i_cfg_data[MAX_DIST_BITS-1:0];
                CFG_ALARM_Q4: r_alarm_q4 <= i_cfg_data[DIST_CM_BITS-1:0];
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[WAIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_start <= i_s_tdata[0];
            r_echo  <= i_s_tdata[1];
        end
    end

    ura_seq #(
        .COUNT_BITS(COUNT_BITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (r_in_vld),
        .i_start   (r_start),
        .i_echo    (r_echo),
        .i_timeout (r_timeout),
        .o_ready   (seq_ready),
        .o_vld     (seq_vld),
        .o_flags   (seq_flags),
        .o_count   (seq_count),
        .i_ready   (conv_ready)
    );

    ura_conv #(
        .COUNT_BITS(COUNT_BITS)
    ) u_conv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (seq_vld),
        .i_flags    (seq_flags),
        .i_count    (seq_count),
        .i_max_dist (r_max_dist),
        .o_ready    (conv_ready),
        .o_vld      (conv_vld),
        .o_rd       (conv_rd),
        .i_ready    (trk_ready)
    );

    ura_track u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (conv_vld),
        .i_rd       (conv_rd),
        .i_alarm_q4 (r_alarm_q4),
        .o_ready    (trk_ready),
        .o_vld      (o_m_tvalid),
        .o_rd       (out_rd),
        .o_alarm    (out_alarm),
        .o_changed  (out_chg),
        .i_ready    (i_m_tready)
    );

    assign o_m_tdata = {out_chg, out_alarm, out_rd.inch, out_rd.cm,
                        out_rd.valid, out_rd.done, out_rd.trig};

endmodule
